// File: design/dcft_pkg.sv
// shared types, constants and helpers for the dimmer channel core
package dcft_pkg;

   localparam int LEVEL_BITS = 8;
   localparam int TIME_BITS  = 32;
   localparam int CNT_BITS   = 4;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;

   // request payload: op, param, duration_ms, now_ms
   localparam int REQ_W = 80;
   // result payload: drive_level, is_on, level_value, event_count
   localparam int RSP_W = 24;

   localparam logic [1:0] CSR_PWM_MODE       = 2'd0;
   localparam logic [1:0] CSR_INVERT_OUTPUT  = 2'd1;
   localparam logic [1:0] CSR_EVENTS_ENABLED = 2'd2;

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [TIME_BITS-1:0]  time_type;

   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_ON     = 3'd1,
      OP_OFF    = 3'd2,
      OP_TOGGLE = 3'd3,
      OP_SET    = 3'd4,
      OP_INC    = 3'd5,
      OP_TICK   = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK,
      ST_DIV,
      ST_APPLY,
      ST_DEADLINE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic tick_eval;
      logic div_step;
      logic apply;
      logic deadline;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic go_tick;
      logic fade_on;
      logic fade_done;
      logic div_last;
      logic rsp_free;
   } sts_type;

   // add that sticks at the top of the time range
   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
   endfunction

endpackage

// File: design/dimmer_channel_fade_timeout_core.sv
// top level of the dimmer channel with linear fade and auto-toggle timer
//
// one request transaction (op, signed param, duration_ms, now_ms) gives exactly one
// result transaction (drive_level, is_on, level_value, event_count).
// config: csr_valid/csr_index/csr_data write pwm_mode (0), invert_output (1) and
// events_enabled (2); csr_ready is always high, write only while no transaction is open.
// path from request to result valid: none, on, off, toggle and level ops without
// duration go through exec and out; a tick with no fade running goes through exec,
// tick, deadline and out; a finishing fade adds apply, a fade step adds the divide.
// the fade step is a serial scaled divide of 16 half-steps, one per cycle, in the
// datapath, which makes it the longest path of a transaction.
// one transaction is worked on at a time; req_tready is high only while idle.
// results sit in an output register, so a new request is taken while the
// previous result still waits; a stalled rsp_tready holds the result and the
// block only stops once its next result is ready to load.
// synchronous reset clears the level, on flag, fade, deadline and config to zero.
module dimmer_channel_fade_timeout_core
   import dcft_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // op[2:0], param[11:3], duration_ms[43:12], now_ms[75:44]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // drive_level[7:0], is_on[8], level_value[16:9], event_count[18:17]
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic             csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   dcft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dcft_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// File: design/dcft_ctrl.sv
// sequencer for one transaction: op decode, fade tick, serial divide, result load
module dcft_ctrl
   import dcft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.go_tick ? ST_TICK : ST_OUT;
         end
         ST_TICK: begin
            if (!sts.fade_on) state_in = ST_DEADLINE;
            else if (sts.fade_done) state_in = ST_APPLY;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_last) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_DEADLINE;
         end
         ST_DEADLINE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC:     cmd.exec      = 1'b1;
         ST_TICK:     cmd.tick_eval = 1'b1;
         ST_DIV:      cmd.div_step  = 1'b1;
         ST_APPLY:    cmd.apply     = 1'b1;
         ST_DEADLINE: cmd.deadline  = 1'b1;
         ST_OUT:      cmd.load_rsp  = sts.rsp_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: design/dcft_datapath.sv
// channel state, fade divider, config registers and result register
module dcft_datapath
   import dcft_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic             csr_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   input  cmd_type          cmd,
   output sts_type          sts
);

   // captured transaction
   op_type          op_ff, op_in;
   logic [8:0]      param_ff, param_in;
   time_type        dur_ff, dur_in;
   time_type        now_ff, now_in;

   // channel state
   level_type       level_ff, level_in;
   logic            on_ff, on_in;
   level_type       from_ff, from_in;
   level_type       to_ff, to_in;
   time_type        start_ff, start_in;
   time_type        end_ff, end_in;
   logic            fade_valid_ff, fade_valid_in;
   time_type        deadline_ff, deadline_in;
   logic            dl_valid_ff, dl_valid_in;
   logic [1:0]      events_ff, events_in;

   // config
   logic            pwm_ff, pwm_in;
   logic            inv_ff, inv_in;
   logic            ev_en_ff, ev_en_in;

   // divider
   time_type        d_ff, d_in;
   time_type        t_ff, t_in;
   time_type        r_ff, r_in;
   level_type       a_ff, a_in;
   level_type       q_ff, q_in;
   logic            dir_ff, dir_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [9:0] v_sum;
   level_type       v_clamp;
   logic            dl_expired;
   time_type        d_minus;
   logic            step_ge;
   level_type       nv;
   level_type       drive;
   logic            bit_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         on_ff         <= 1'b0;
         from_ff       <= '0;
         to_ff         <= '0;
         start_ff      <= '0;
         end_ff        <= '0;
         fade_valid_ff <= 1'b0;
         deadline_ff   <= '0;
         dl_valid_ff   <= 1'b0;
         events_ff     <= '0;
         pwm_ff        <= 1'b0;
         inv_ff        <= 1'b0;
         ev_en_ff      <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         level_ff      <= level_in;
         on_ff         <= on_in;
         from_ff       <= from_in;
         to_ff         <= to_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         fade_valid_ff <= fade_valid_in;
         deadline_ff   <= deadline_in;
         dl_valid_ff   <= dl_valid_in;
         events_ff     <= events_in;
         pwm_ff        <= pwm_in;
         inv_ff        <= inv_in;
         ev_en_ff      <= ev_en_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      param_ff    <= param_in;
      dur_ff      <= dur_in;
      now_ff      <= now_in;
      d_ff        <= d_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      a_ff        <= a_in;
      q_ff        <= q_in;
      dir_ff      <= dir_in;
      rsp_data_ff <= rsp_data_in;
   end

   // target level for set and increment, clamped to the level range
   always_comb begin
      if (op_ff == OP_INC) v_sum = $signed({param_ff[8], param_ff}) + $signed({2'b00, level_ff});
      else v_sum = $signed({param_ff[8], param_ff});
      if (v_sum < 10'sd0) v_clamp = '0;
      else if (v_sum > $signed({2'b00, LEVEL_MAX})) v_clamp = LEVEL_MAX;
      else v_clamp = v_sum[LEVEL_BITS-1:0];
   end

   assign dl_expired = dl_valid_ff && !(deadline_ff > now_ff);

   // one half-step of the scaled quotient: doubling, or adding t when the bit of a is set
   always_comb begin
      bit_a   = a_ff[cnt_ff[CNT_BITS-1:1]];
      d_minus = cnt_ff[0] ? d_ff - r_ff : d_ff - t_ff;
      step_ge = cnt_ff[0] ? (r_ff >= d_minus) : (bit_a && (r_ff >= d_minus));
   end

   assign nv = fade_valid_ff ? (dir_ff ? from_ff + q_ff : from_ff - q_ff) : to_ff;

   always_comb begin
      if (pwm_ff) begin
         if (on_ff) drive = inv_ff ? LEVEL_MAX - level_ff : level_ff;
         else drive = inv_ff ? LEVEL_MAX : '0;
      end else begin
         drive = {{(LEVEL_BITS-1){1'b0}}, on_ff ^ inv_ff};
      end
   end

   always_comb begin
      op_in         = op_ff;
      param_in      = param_ff;
      dur_in        = dur_ff;
      now_in        = now_ff;
      level_in      = level_ff;
      on_in         = on_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      fade_valid_in = fade_valid_ff;
      deadline_in   = deadline_ff;
      dl_valid_in   = dl_valid_ff;
      events_in     = events_ff;
      d_in          = d_ff;
      t_in          = t_ff;
      r_in          = r_ff;
      a_in          = a_ff;
      q_in          = q_ff;
      dir_in        = dir_ff;
      cnt_in        = cnt_ff;
      pwm_in        = pwm_ff;
      inv_in        = inv_ff;
      ev_en_in      = ev_en_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_PWM_MODE:       pwm_in   = csr_data;
            CSR_INVERT_OUTPUT:  inv_in   = csr_data;
            CSR_EVENTS_ENABLED: ev_en_in = csr_data;
            default: begin
               pwm_in = pwm_ff;
            end
         endcase
      end

      if (cmd.capture) begin
         op_in     = op_type'(req_tdata[2:0]);
         param_in  = req_tdata[11:3];
         dur_in    = req_tdata[43:12];
         now_in    = req_tdata[75:44];
         events_in = '0;
      end

      if (cmd.exec) begin
         case (op_ff)
            OP_NONE: begin
               dl_valid_in = 1'b0;
               events_in   = events_ff + 2'd1;
            end
            OP_ON, OP_OFF, OP_TOGGLE: begin
               if (op_ff == OP_ON) on_in = 1'b1;
               else if (op_ff == OP_OFF) on_in = 1'b0;
               else on_in = ~on_ff;
               dl_valid_in = (dur_ff != '0);
               deadline_in = sat_add(now_ff, dur_ff);
               events_in   = events_ff + 2'd1;
            end
            OP_SET, OP_INC: begin
               if (dur_ff != '0) begin
                  from_in       = level_ff;
                  to_in         = v_clamp;
                  start_in      = now_ff;
                  end_in        = sat_add(now_ff, dur_ff);
                  fade_valid_in = 1'b1;
               end else begin
                  level_in      = v_clamp;
                  fade_valid_in = 1'b0;
                  if (dl_expired) dl_valid_in = 1'b0;
                  events_in     = events_ff + 2'd1;
               end
            end
            default: begin
               events_in = events_ff;
            end
         endcase
      end

      if (cmd.tick_eval && fade_valid_ff) begin
         if (sts.fade_done) begin
            fade_valid_in = 1'b0;
            events_in     = events_ff + 2'd1;
         end else begin
            d_in   = end_ff - start_ff;
            t_in   = (now_ff > start_ff) ? now_ff - start_ff : '0;
            dir_in = (to_ff >= from_ff);
            a_in   = (to_ff >= from_ff) ? to_ff - from_ff : from_ff - to_ff;
            r_in   = '0;
            q_in   = '0;
            cnt_in = '1;
         end
      end

      if (cmd.div_step) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff[0]) begin
            q_in = {q_ff[LEVEL_BITS-2:0], step_ge};
            r_in = step_ge ? r_ff - d_minus : r_ff + r_ff;
         end else if (bit_a) begin
            q_in = q_ff + {{(LEVEL_BITS-1){1'b0}}, step_ge};
            r_in = step_ge ? r_ff - d_minus : r_ff + t_ff;
         end
      end

      if (cmd.apply && (nv != level_ff)) begin
         level_in = nv;
         if (dl_expired) dl_valid_in = 1'b0;
      end

      if (cmd.deadline && dl_valid_ff && (now_ff > deadline_ff)) begin
         on_in       = ~on_ff;
         dl_valid_in = 1'b0;
         events_in   = events_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, (ev_en_ff ? events_ff : 2'b00), level_ff, on_ff, drive};
      end
   end

   always_comb begin
      sts.go_tick   = (op_ff == OP_TICK) ||
                      (((op_ff == OP_SET) || (op_ff == OP_INC)) && (dur_ff != '0));
      sts.fade_on   = fade_valid_ff;
      sts.fade_done = (now_ff >= end_ff) || (end_ff <= start_ff);
      sts.div_last  = (cnt_ff == '0);
      sts.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/dcft_checker.sv
// port-level checks for the dimmer channel core, bound to the top level
module dcft_checker
   import dcft_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [1:0]       csr_index,
   input logic             csr_data
);

   // result register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one transaction at a time: busy the cycle after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // at most two events per transaction
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:17] != 2'b11))
      else $error("event count out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind dimmer_channel_fade_timeout_core dcft_checker u_dcft_checker (.*);

// File: sim/dimmer_channel_fade_timeout_core_tb.sv
// self-checking testbench for the dimmer channel core: directed and random commands
module dimmer_channel_fade_timeout_core_tb;
   import dcft_pkg::*;

   localparam int LVL_TOP = LEVEL_MAX;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   typedef struct {
      logic [2:0]        op;
      logic signed [8:0] param;
      time_type          dur;
      time_type          now;
   } stim_type;

   typedef struct {
      level_type  drive;
      logic       on;
      level_type  lvl;
      logic [1:0] ev;
   } expect_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;  // op, param, duration_ms, now_ms
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;      // drive_level, is_on, level_value, event_count
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = '0;
   logic             csr_data = 1'b0;

   dimmer_channel_fade_timeout_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stim_type   cmd_backlog[$];
   expect_type owed_outputs[$];
   int     faults = 0;
   int     results_seen = 0;
   int     cycle_count = 0;
   time_type wall_ms = '0;

   // channel state as the block should hold it
   int       lvl = 0;
   logic     lamp_on = 1'b0;
   int       fade_from = 0;
   int       fade_to = 0;
   time_type fade_t0 = '0;
   time_type fade_t1 = '0;
   logic     fade_live = 1'b0;
   time_type due_at = '0;
   logic     due_live = 1'b0;
   logic     cfg_pwm = 1'b0;
   logic     cfg_inv = 1'b0;
   logic     cfg_evt = 1'b0;

   function automatic time_type clamp_add(input time_type a, input time_type b);
      return (b > ~a) ? '1 : a + b;
   endfunction

   function automatic void drop_stale_deadline(input time_type now);
      if (due_live && !(due_at > now)) due_live = 1'b0;
   endfunction

   function automatic int run_fade(input time_type now);
      int ev;
      int nv;
      longint unsigned span, el;
      ev = 0;
      if (fade_live) begin
         if (now >= fade_t1 || fade_t1 <= fade_t0) begin
            nv = fade_to;
            fade_live = 1'b0;
            ev++;
         end else begin
            span = fade_t1 - fade_t0;
            el = (now > fade_t0) ? now - fade_t0 : 0;
            if (fade_to >= fade_from)
               nv = fade_from + int'(el * (fade_to - fade_from) / span);
            else
               nv = fade_from - int'(el * (fade_from - fade_to) / span);
            if (nv > LVL_TOP) nv = LVL_TOP;
         end
         if (nv != lvl) begin
            lvl = nv;
            drop_stale_deadline(now);
         end
      end
      if (due_live && now > due_at) begin
         lamp_on = ~lamp_on;
         due_live = 1'b0;
         ev++;
      end
      return ev;
   endfunction

   function automatic expect_type step_channel(input stim_type c);
      int         ev, v, drv;
      expect_type r;
      ev = 0;
      case (c.op)
         OP_NONE: begin
            due_live = 1'b0;
            ev = 1;
         end
         OP_ON, OP_OFF, OP_TOGGLE: begin
            if (c.op == OP_ON) lamp_on = 1'b1;
            else if (c.op == OP_OFF) lamp_on = 1'b0;
            else lamp_on = ~lamp_on;
            if (c.dur != 0) begin
               due_at = clamp_add(c.now, c.dur);
               due_live = 1'b1;
            end else begin
               due_live = 1'b0;
            end
            ev = 1;
         end
         OP_SET, OP_INC: begin
            v = (c.op == OP_INC) ? int'(c.param) + lvl : int'(c.param);
            if (v < 0) v = 0;
            if (v > LVL_TOP) v = LVL_TOP;
            if (c.dur != 0) begin
               fade_from = lvl;
               fade_to = v;
               fade_t0 = c.now;
               fade_t1 = clamp_add(c.now, c.dur);
               fade_live = 1'b1;
               ev = run_fade(c.now);
            end else begin
               lvl = v;
               fade_live = 1'b0;
               drop_stale_deadline(c.now);
               ev = 1;
            end
         end
         OP_TICK: ev = run_fade(c.now);
         default: ;
      endcase
      if (cfg_pwm)
         drv = lamp_on ? (cfg_inv ? LVL_TOP - lvl : lvl) : (cfg_inv ? LVL_TOP : 0);
      else
         drv = int'(lamp_on ^ cfg_inv);
      r.drive = drv[7:0];
      r.on    = lamp_on;
      r.lvl   = lvl[7:0];
      r.ev    = cfg_evt ? ev[1:0] : 2'd0;
      return r;
   endfunction

   // sender: bursts of random length separated by random gaps
   int       burst_left = 1;
   int       gap_left = 0;
   stim_type on_wire;

   always @(posedge clock) begin : tx
      stim_type c;
      logic     launch;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PWM_MODE) cfg_pwm = csr_data;
            else if (csr_index == CSR_INVERT_OUTPUT) cfg_inv = csr_data;
            else if (csr_index == CSR_EVENTS_ENABLED) cfg_evt = csr_data;
         end
         if (req_tvalid && req_tready) owed_outputs = {owed_outputs, step_channel(on_wire)};
         if (!req_tvalid || req_tready) begin
            launch = 1'b0;
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (cmd_backlog.size() > 0) begin
               c = cmd_backlog.pop_front();
               on_wire = c;
               req_tdata <= {4'b0, c.now, c.dur, c.param, c.op};
               launch = 1'b1;
               burst_left = burst_left - 1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
            req_tvalid <= launch;
         end
      end
   end

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         faults++;
         $display("%0t mismatch %s: expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // receiver: stall pattern changes at random, plus one long hold-off after 160 results
   int   stall_mode = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   logic alt_bit = 1'b0;

   always @(posedge clock) begin : rx
      expect_type want;
      logic       ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (owed_outputs.size() == 0) begin
               faults++;
               $display("%0t unexpected transaction: expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = owed_outputs.pop_front();
               check_field("drive_level", want.drive, rsp_tdata[7:0]);
               check_field("is_on", want.on, rsp_tdata[8]);
               check_field("level_value", want.lvl, rsp_tdata[16:9]);
               check_field("event_count", want.ev, rsp_tdata[18:17]);
            end
         end
         if (!hold_done && results_seen >= 160) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            ready_next = 1'b0;
         end else begin
            if (stall_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               stall_left = $urandom_range(10, 60);
            end
            stall_left = stall_left - 1;
            alt_bit = ~alt_bit;
            case (stall_mode)
               0: ready_next = 1'b1;
               1: ready_next = 1'($urandom_range(0, 1));
               2: ready_next = ($urandom_range(0, 5) == 0);
               default: ready_next = alt_bit;
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_modes(input logic pwm, input logic inv, input logic evt);
      write_csr(CSR_PWM_MODE, pwm);
      write_csr(CSR_INVERT_OUTPUT, inv);
      write_csr(CSR_EVENTS_ENABLED, evt);
   endtask

   task automatic wait_drained;
      while (cmd_backlog.size() != 0 || req_tvalid || owed_outputs.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_cmd(input logic [2:0] op, input logic [8:0] p,
                            input time_type d, input time_type n);
      stim_type c;
      c.op = op;
      c.param = p;
      c.dur = d;
      c.now = n;
      cmd_backlog = {cmd_backlog, c};
   endtask

   // mostly forward-moving time so fades and deadlines get walked through
   task automatic queue_random(input int count);
      stim_type c;
      int       pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) c.op = OP_TICK;
         else if (pick < 50) c.op = OP_SET;
         else if (pick < 65) c.op = OP_INC;
         else if (pick < 73) c.op = OP_ON;
         else if (pick < 81) c.op = OP_OFF;
         else if (pick < 90) c.op = OP_TOGGLE;
         else if (pick < 95) c.op = OP_NONE;
         else c.op = OP_UNUSED;

         if (c.op == OP_SET && $urandom_range(0, 1) == 0)
            c.param = 9'($urandom_range(0, 255));
         else if (c.op == OP_INC && $urandom_range(0, 4) < 3)
            c.param = 9'($urandom_range(0, 80) - 40);
         else
            c.param = 9'($urandom);

         pick = $urandom_range(0, 19);
         if (pick < 6) c.dur = '0;
         else if (pick < 16) c.dur = $urandom_range(1, 150);
         else if (pick < 18) c.dur = $urandom;
         else if (pick < 19) c.dur = '1;
         else c.dur = $urandom_range(1, 3);

         if ($urandom_range(0, 49) == 0) wall_ms = '1 - $urandom_range(0, 400);
         else wall_ms = wall_ms + $urandom_range(0, 25);
         c.now = ($urandom_range(0, 24) == 0) ? time_type'($urandom) : wall_ms;
         cmd_backlog = {cmd_backlog, c};
      end
   endtask

   initial begin
      logic [2:0] modes;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // registers still at their reset values
      queue_cmd(OP_SET, 9'd77, 0, 0);
      queue_cmd(OP_ON, 9'd0, 0, 1);
      wait_drained();

      set_modes(1'b1, 1'b0, 1'b1);
      queue_cmd(OP_NONE, 9'd0, 0, 0);
      queue_cmd(OP_ON, 9'h1FF, 0, 10);
      queue_cmd(OP_SET, 9'd255, 0, 11);
      queue_cmd(OP_SET, 9'h100, 0, 12);
      queue_cmd(OP_INC, 9'd255, 0, 13);
      queue_cmd(OP_INC, 9'h100, 0, 14);
      // upward fade: a tick midway, one before its start, then one at its end
      queue_cmd(OP_SET, 9'd200, 100, 1000);
      queue_cmd(OP_TICK, 9'd0, 0, 1050);
      queue_cmd(OP_TICK, 9'd0, 0, 999);
      queue_cmd(OP_TICK, 9'd0, 0, 1100);
      // downward fade with truncation
      queue_cmd(OP_SET, 9'd10, 7, 2000);
      queue_cmd(OP_TICK, 9'd0, 0, 2003);
      // auto-toggle fires only strictly after the deadline
      queue_cmd(OP_TOGGLE, 9'd0, 10, 3000);
      queue_cmd(OP_TICK, 9'd0, 0, 3010);
      queue_cmd(OP_TICK, 9'd0, 0, 3011);
      // deadline and fade end saturate at the top of the time range
      queue_cmd(OP_OFF, 9'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
      queue_cmd(OP_TICK, 9'd0, 0, 32'hFFFF_FFFF);
      queue_cmd(OP_SET, 9'd50, 5, 32'hFFFF_FFFF);
      // level change drops a deadline that is already due
      queue_cmd(OP_ON, 9'd0, 20, 4000);
      queue_cmd(OP_SET, 9'd60, 0, 4030);
      queue_cmd(OP_TICK, 9'd0, 0, 4040);
      // fade end and deadline in the same tick
      queue_cmd(OP_SET, 9'd60, 2, 5000);
      queue_cmd(OP_TOGGLE, 9'd0, 1, 5001);
      queue_cmd(OP_TICK, 9'd0, 0, 5010);
      queue_cmd(OP_UNUSED, 9'h0AA, 32'hAAAA_AAAA, 32'h5555_5555);
      queue_cmd(OP_INC, -9'sd30, 20, 6000);
      wait_drained();

      wall_ms = 32'd10000;
      for (int k = 0; k < 8; k++) begin
         modes = k[2:0];
         set_modes(modes[0], modes[1], modes[2]);
         queue_random(68);
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (faults == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
design/dcft_pkg.sv
design/dcft_ctrl.sv
design/dcft_datapath.sv
design/dimmer_channel_fade_timeout_core.sv
design/dcft_checker.sv
sim/dimmer_channel_fade_timeout_core_tb.sv
